/* hdl/spi_temp_sensor_registers_top_defines.svh */
// Assertion macros shared by the RTL files.
`ifndef SPI_TEMP_SENSOR_REGISTERS_TOP_DEFINES_SVH
`define SPI_TEMP_SENSOR_REGISTERS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check c in the same cycle as a.
`define SPTSR_ASSERT_SAME(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Check c in the cycle after a.
`define SPTSR_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SPTSR_ASSERT_SAME(lbl, a, c)
`define SPTSR_ASSERT_NEXT(lbl, a, c)
`endif

`endif

/* hdl/sptsr_pkg.sv */
package sptsr_pkg;

    // Transfer phases
    localparam logic [1:0] PH_CMD    = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // Register addresses
    localparam logic [2:0] ADDR_STATUS = 3'd0;
    localparam logic [2:0] ADDR_CONFIG = 3'd1;
    localparam logic [2:0] ADDR_TEMP   = 3'd2;
    localparam logic [2:0] ADDR_ID     = 3'd3;

    // Operating modes
    localparam logic [1:0] MODE_CONT     = 2'd0;
    localparam logic [1:0] MODE_SHUTDOWN = 2'd3;

    localparam logic [7:0] ID_RESET = 8'hC0;

    localparam int unsigned SP_COUNT = 4;
    localparam logic [15:0] SP_RESET [SP_COUNT] = '{16'h4980, 16'h0005, 16'h2000, 16'h0500};

    // Item passed from the front queue to the register engine
    typedef struct packed {
        logic        is_conv;
        logic        byte_zero;
        logic [7:0]  data_byte;
        logic [15:0] temp_sample;
    } t_item;

endpackage

/* hdl/sptsr_front.sv */
`include "spi_temp_sensor_registers_top_defines.svh"

module sptsr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [7:0]       i_data_byte,
    input  logic [15:0]      i_temp_sample,
    output logic             o_q_valid,
    input  logic             i_q_pop,
    output sptsr_pkg::t_item o_q_item
);

    sptsr_pkg::t_item r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;
    sptsr_pkg::t_item in_item;

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    // Classify on entry: mark zero data bytes for the engine
    always_comb begin
        in_item.is_conv     = i_command;
        in_item.byte_zero   = (i_data_byte == 8'h00);
        in_item.data_byte   = i_data_byte;
        in_item.temp_sample = i_temp_sample;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SPTSR_ASSERT_SAME(a_empty_ptrs, r_count == 2'd0, r_wr_ptr == r_rd_ptr)
    `SPTSR_ASSERT_SAME(a_full_ptrs, r_count == 2'd2, r_wr_ptr == r_rd_ptr)
    `SPTSR_ASSERT_SAME(a_one_ptrs, r_count == 2'd1, r_wr_ptr != r_rd_ptr)

endmodule

/* hdl/sptsr_back.sv */
`include "spi_temp_sensor_registers_top_defines.svh"

module sptsr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  sptsr_pkg::t_item i_q_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_miso_byte,
    output logic             o_byte_valid,
    output logic             o_not_ready,
    output logic [1:0]       o_op_mode,
    output logic             o_high_resolution
);

    logic [7:0]  r_id;
    logic        r_not_ready;
    logic [2:0]  r_cfg;
    logic [15:0] r_temp;
    logic [15:0] r_sp [sptsr_pkg::SP_COUNT];
    logic [1:0]  r_phase;
    logic [2:0]  r_addr;
    logic        r_rd;
    logic        r_cont;

    logic        n_not_ready;
    logic [2:0]  n_cfg;
    logic [15:0] n_temp;
    logic [15:0] n_sp_val;
    logic        n_sp_we;
    logic [1:0]  n_phase;
    logic [2:0]  n_addr;
    logic        n_rd;
    logic        n_cont;

    logic        r_out_valid;
    logic [7:0]  r_out_miso;
    logic        r_out_byte_valid;
    logic [7:0]  n_miso;
    logic        n_byte_valid;

    logic        take;
    logic [1:0]  mode;
    logic [15:0] sp_cur;
    logic [15:0] conv_val;

    // temperature read step, shared by the status and temperature addresses
    logic [7:0]  tr_miso;
    logic        tr_valid;
    logic [1:0]  tr_phase;
    logic        tr_set_rdy;

    assign take    = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = take;
    assign mode    = r_cfg[1:0];
    assign sp_cur  = r_sp[r_addr[1:0]];

    always_comb begin
        conv_val = {i_q_item.temp_sample[15], i_q_item.temp_sample[15:1]};
        if (!r_cfg[2]) begin
            conv_val[2:0] = 3'b000;
        end
    end

    always_comb begin
        tr_miso    = 8'h00;
        tr_valid   = 1'b0;
        tr_phase   = sptsr_pkg::PH_CMD;
        tr_set_rdy = 1'b1;
        if (i_q_item.byte_zero) begin
            tr_valid = 1'b1;
            if (r_phase == sptsr_pkg::PH_FIRST) begin
                tr_miso    = r_temp[15:8];
                tr_phase   = sptsr_pkg::PH_SECOND;
                tr_set_rdy = 1'b0;
            end else begin
                tr_miso  = r_temp[7:0];
                tr_phase = r_cont ? sptsr_pkg::PH_FIRST : sptsr_pkg::PH_CMD;
            end
        end
    end

    always_comb begin
        n_not_ready  = r_not_ready;
        n_cfg        = r_cfg;
        n_temp       = r_temp;
        n_sp_val     = sp_cur;
        n_sp_we      = 1'b0;
        n_phase      = r_phase;
        n_addr       = r_addr;
        n_rd         = r_rd;
        n_cont       = r_cont;
        n_miso       = 8'h00;
        n_byte_valid = 1'b0;
        if (i_q_item.is_conv) begin
            if (mode != sptsr_pkg::MODE_SHUTDOWN) begin
                n_temp      = conv_val;
                n_not_ready = 1'b0;
            end
        end else if (r_phase != sptsr_pkg::PH_FIRST && r_phase != sptsr_pkg::PH_SECOND) begin
            n_rd    = i_q_item.data_byte[6];
            n_addr  = i_q_item.data_byte[5:3];
            n_cont  = i_q_item.data_byte[2];
            n_phase = sptsr_pkg::PH_FIRST;
        end else begin
            case (r_addr)
                sptsr_pkg::ADDR_STATUS: begin
                    if (!r_rd && mode == sptsr_pkg::MODE_CONT) begin
                        n_miso       = tr_miso;
                        n_byte_valid = tr_valid;
                        n_phase      = tr_phase;
                        if (tr_set_rdy) begin
                            n_not_ready = 1'b1;
                        end
                    end else begin
                        n_miso       = {r_not_ready, 7'b0};
                        n_byte_valid = 1'b1;
                        n_not_ready  = 1'b1;
                        n_phase      = sptsr_pkg::PH_CMD;
                    end
                end
                sptsr_pkg::ADDR_CONFIG: begin
                    if (r_rd) begin
                        n_miso       = {r_cfg, 5'b0};
                        n_byte_valid = 1'b1;
                    end else begin
                        n_cfg = i_q_item.data_byte[7:5];
                    end
                    n_phase = sptsr_pkg::PH_CMD;
                end
                sptsr_pkg::ADDR_TEMP: begin
                    n_miso       = tr_miso;
                    n_byte_valid = tr_valid;
                    n_phase      = tr_phase;
                    if (tr_set_rdy) begin
                        n_not_ready = 1'b1;
                    end
                end
                sptsr_pkg::ADDR_ID: begin
                    if (i_q_item.byte_zero) begin
                        n_miso       = r_id;
                        n_byte_valid = 1'b1;
                    end
                    n_phase = sptsr_pkg::PH_CMD;
                end
                default: begin
                    // setpoints: high byte first
                    if (!r_rd) begin
                        n_sp_we = 1'b1;
                        if (r_phase == sptsr_pkg::PH_FIRST) begin
                            n_sp_val = {i_q_item.data_byte, sp_cur[7:0]};
                            n_phase  = sptsr_pkg::PH_SECOND;
                        end else begin
                            n_sp_val = {sp_cur[15:8], i_q_item.data_byte};
                            n_phase  = sptsr_pkg::PH_CMD;
                        end
                    end else if (!i_q_item.byte_zero) begin
                        n_phase = sptsr_pkg::PH_CMD;
                    end else if (r_phase == sptsr_pkg::PH_FIRST) begin
                        n_miso       = sp_cur[15:8];
                        n_byte_valid = 1'b1;
                        n_phase      = sptsr_pkg::PH_SECOND;
                    end else begin
                        n_miso       = sp_cur[7:0];
                        n_byte_valid = 1'b1;
                        n_phase      = sptsr_pkg::PH_CMD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id        <= sptsr_pkg::ID_RESET;
            r_not_ready <= 1'b1;
            r_cfg       <= 3'b000;
            r_temp      <= 16'h0000;
            for (int i = 0; i < sptsr_pkg::SP_COUNT; i++) begin
                r_sp[i] <= sptsr_pkg::SP_RESET[i];
            end
            r_phase     <= sptsr_pkg::PH_CMD;
            r_addr      <= 3'd0;
            r_rd        <= 1'b0;
            r_cont      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_id <= i_cfg_wr_data;
            end
            if (take) begin
                r_not_ready <= n_not_ready;
                r_cfg       <= n_cfg;
                r_temp      <= n_temp;
                if (n_sp_we) begin
                    r_sp[r_addr[1:0]] <= n_sp_val;
                end
                r_phase     <= n_phase;
                r_addr      <= n_addr;
                r_rd        <= n_rd;
                r_cont      <= n_cont;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output stage payload; status flags are held with the item
    logic       r_out_not_ready;
    logic [2:0] r_out_cfg;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_miso       <= n_miso;
            r_out_byte_valid <= n_byte_valid;
            r_out_not_ready  <= n_not_ready;
            r_out_cfg        <= n_cfg;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_miso_byte       = r_out_miso;
    assign o_byte_valid      = r_out_byte_valid;
    assign o_not_ready       = r_out_not_ready;
    assign o_op_mode         = r_out_cfg[1:0];
    assign o_high_resolution = r_out_cfg[2];

    `SPTSR_ASSERT_NEXT(a_conv_clears_rdy,
        take && i_q_item.is_conv && mode != sptsr_pkg::MODE_SHUTDOWN, !r_not_ready)
    `SPTSR_ASSERT_NEXT(a_low_res_trunc,
        take && i_q_item.is_conv && mode != sptsr_pkg::MODE_SHUTDOWN && !r_cfg[2],
        r_temp[2:0] == 3'b000)
    `SPTSR_ASSERT_SAME(a_idle_byte_zero, r_out_valid && !r_out_byte_valid, r_out_miso == 8'h00)

endmodule

/* hdl/spi_temp_sensor_registers_top.sv */
// An accepted item is registered in the front queue and then in the register engine
//   output stage; its result shows when the output is free.
// Throughput: one item per cycle, with the engine retiring one, unless the output stalls.
// The two-entry front queue and the output stage let either side stall on its own.
// Reset: synchronous, active low; clears queue, transfer state, registers to their
//   power-on values and the ID value to 0xC0.
module spi_temp_sensor_registers_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] temp_sample
    input  logic        s_axis_tuser,  // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] miso_byte, [8] not_ready, [10:9] op_mode,
                                       // [11] high_resolution, [15:12] zero
    output logic        m_axis_tuser   // [0] byte_valid
);

    logic             q_valid;
    logic             q_pop;
    sptsr_pkg::t_item q_item;
    logic [7:0]       miso_byte;
    logic             not_ready;
    logic [1:0]       op_mode;
    logic             high_res;

    sptsr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_command     (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_temp_sample (s_axis_tdata[23:8]),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_item      (q_item)
    );

    sptsr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_q_valid         (q_valid),
        .o_q_pop           (q_pop),
        .i_q_item          (q_item),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_miso_byte       (miso_byte),
        .o_byte_valid      (m_axis_tuser),
        .o_not_ready       (not_ready),
        .o_op_mode         (op_mode),
        .o_high_resolution (high_res)
    );

    assign m_axis_tdata = {4'b0000, high_res, op_mode, not_ready, miso_byte};

endmodule
